FILE: hw/rtl/cma_pkg.sv
// Shared codes and types of the contiguous memory allocator.
`timescale 1ns / 1ps
package cma_pkg;
	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_NO_HOLE  = 3'd1,
		ST_NO_OWNER = 3'd2,
		ST_FULL     = 3'd3,
		ST_BAD_SIZE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_RELEASE = 2'd1,
		OP_COMPACT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NONE  = 2'd3
	} policy_t;

	// Verdict of the hole compare unit for one hole.
	typedef struct packed {
		logic fits;
		logic take;
	} fit_t;
endpackage

FILE: hw/rtl/cma_fit_unit.sv
// Shared hole compare unit: hole length, fit test and policy ranking.
`timescale 1ns / 1ps
module cma_fit_unit import cma_pkg::*; #(
	parameter int AW = 20
) (
	input  logic [AW:0] hole_lo,
	input  logic [AW:0] hole_top,
	input  logic [AW:0] size,
	input  logic [1:0]  policy,
	input  logic        found,
	input  logic [AW:0] pick_left,
	output logic [AW:0] left,
	output fit_t        verdict
);
	logic [AW:0] len;

	always_comb begin
		len = (hole_top > hole_lo) ? hole_top - hole_lo : '0;
		left = len - size;
		verdict.fits = (len >= size) && (policy != POL_NONE);
		verdict.take = verdict.fits && (!found ||
			(policy == POL_BEST && left < pick_left) ||
			(policy == POL_WORST && left > pick_left));
	end
endmodule

FILE: hw/rtl/contiguous_memory_allocator.sv
// Top level of the contiguous memory allocator: segment table and sequencer.
//
// channel   direction  handshake               payload
// command   in         start & !busy           op, policy, request_size, owner_id
// result    out        done, one cycle         status, range_first, range_last
// config    in         memory_size_we          memory_size
//
// Each table step has two phases: one for the table read, one for the use of its word.
// A request scans holes and moves entries up, a release searches entries and moves them
// down, a compact walks all cnt_q entries; the pace, also with a full table of 64, is
// set by the single table read port.
// Reset empties the table at once; the table contents need no clearing.
// The receiver cannot stall: the result word is shown for one cycle only.
`timescale 1ns / 1ps
module contiguous_memory_allocator import cma_pkg::*; #(
	parameter int MAX_SEGMENTS = 64,
	parameter int ADDR_BITS    = 20,
	parameter int OWNER_BITS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [1:0]            policy,
	input  logic [ADDR_BITS:0]    request_size,
	input  logic [OWNER_BITS-1:0] owner_id,
	input  logic                  memory_size_we,
	input  logic [ADDR_BITS:0]    memory_size,
	output logic                  done,
	output logic [2:0]            status,
	output logic [ADDR_BITS-1:0]  range_first,
	output logic [ADDR_BITS-1:0]  range_last
);
	localparam int AW = ADDR_BITS;
	localparam int OW = OWNER_BITS;
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW = 2 * AW + OW;
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SEGMENTS);
	localparam logic [AW:0] LIMIT = {1'b1, {AW{1'b0}}};

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_SHUP = 6'b000100,
		S_FIND = 6'b001000,
		S_SHDN = 6'b010000,
		S_PACK = 6'b100000
	} state_t;

	state_t        state_q;
	logic          ph_q;
	logic [CW-1:0] idx_q, cnt_q, pick_q;
	logic [1:0]    pol_q;
	logic [AW:0]   size_q, lo_q, pick_left_q, pick_lo_q, next_q, msize_q;
	logic [OW-1:0] owner_q;
	logic          found_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [AW-1:0] first_q, last_q;

	logic [EW-1:0] mem [MAX_SEGMENTS];
	logic [EW-1:0] rdata_q;
	logic [AW-1:0] rd_start, rd_end;
	logic [OW-1:0] rd_owner;
	logic          we;
	logic [CW-1:0] waddr, raddr;
	logic [EW-1:0] wdata;

	logic [AW:0]   mem_units, hole_top, left, pack_len, new_last;
	fit_t          verdict;
	logic          scan_end;

	assign {rd_start, rd_end, rd_owner} = rdata_q;
	assign mem_units = (msize_q == '0) ? (AW+1)'(1) : ((msize_q > LIMIT) ? LIMIT : msize_q);
	assign hole_top = (idx_q == cnt_q) ? mem_units : {1'b0, rd_start};
	assign pack_len = {1'b0, rd_end} - {1'b0, rd_start} + (AW+1)'(1);
	assign new_last = pick_lo_q + size_q - (AW+1)'(1);
	assign scan_end = (verdict.take && pol_q == POL_FIRST) || idx_q == cnt_q;

	cma_fit_unit #(.AW(AW)) u_fit (
		.hole_lo(lo_q), .hole_top(hole_top), .size(size_q), .policy(pol_q),
		.found(found_q), .pick_left(pick_left_q), .left(left), .verdict(verdict)
	);

	// Table port control.
	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		raddr = idx_q;
		wdata = rdata_q;
		unique case (state_q)
			S_SHUP: begin
				raddr = idx_q - CW'(1);
				if (idx_q == pick_q) begin
					we = 1'b1;
					wdata = {pick_lo_q[AW-1:0], new_last[AW-1:0], owner_q};
				end else begin
					we = ph_q;
				end
			end
			S_SHDN: begin
				raddr = idx_q + CW'(1);
				we = ph_q && (idx_q + CW'(1) < cnt_q);
			end
			S_PACK: begin
				we = ph_q;
				wdata = {next_q[AW-1:0], AW'(next_q + pack_len - (AW+1)'(1)), rd_owner};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[IW-1:0]] <= wdata;
		end
		rdata_q <= mem[raddr[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
			msize_q <= LIMIT;
			found_q <= 1'b0;
			idx_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (memory_size_we) begin
				msize_q <= memory_size;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pol_q <= policy;
						size_q <= request_size;
						owner_q <= owner_id;
						idx_q <= '0;
						ph_q <= 1'b0;
						lo_q <= '0;
						next_q <= '0;
						found_q <= 1'b0;
						first_q <= '0;
						last_q <= '0;
						unique case (op)
							OP_REQUEST: begin
								if (request_size == '0) begin
									status_q <= ST_BAD_SIZE;
									done_q <= 1'b1;
								end else if (cnt_q == FULL_CNT) begin
									status_q <= ST_FULL;
									done_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_RELEASE: state_q <= S_FIND;
							OP_COMPACT: state_q <= S_PACK;
							default: begin
								status_q <= ST_DONE;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (verdict.take) begin
							found_q <= 1'b1;
							pick_q <= idx_q;
							pick_left_q <= left;
							pick_lo_q <= lo_q;
						end
						lo_q <= {1'b0, rd_end} + (AW+1)'(1);
						idx_q <= idx_q + CW'(1);
						if (scan_end) begin
							if (found_q || verdict.take) begin
								idx_q <= cnt_q;
								state_q <= S_SHUP;
							end else begin
								status_q <= ST_NO_HOLE;
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_SHUP: begin
					if (idx_q == pick_q) begin
						cnt_q <= cnt_q + CW'(1);
						status_q <= ST_DONE;
						first_q <= pick_lo_q[AW-1:0];
						last_q <= new_last[AW-1:0];
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							idx_q <= idx_q - CW'(1);
						end
					end
				end
				S_FIND: begin
					if (!ph_q && idx_q == cnt_q) begin
						status_q <= ST_NO_OWNER;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							if (rd_owner == owner_q) begin
								first_q <= rd_start;
								last_q <= rd_end;
								state_q <= S_SHDN;
							end else begin
								idx_q <= idx_q + CW'(1);
							end
						end
					end
				end
				S_SHDN: begin
					if (idx_q + CW'(1) >= cnt_q) begin
						cnt_q <= cnt_q - CW'(1);
						status_q <= ST_DONE;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				S_PACK: begin
					if (!ph_q && idx_q == cnt_q) begin
						status_q <= ST_DONE;
						if (next_q < mem_units) begin
							first_q <= next_q[AW-1:0];
							last_q <= AW'(mem_units - (AW+1)'(1));
						end
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							next_q <= next_q + pack_len;
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign range_first = first_q;
	assign range_last = last_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word shown while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("segment count above table depth");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (range_first == '0 && range_last == '0))
		else $error("error word carries a range");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(busy) |-> $stable(cnt_q) || $past(done))
		else $error("segment count moved without an operation");
endmodule
